// ===== src/tilt_average_face_match_core_defines.svh =====
// ----------------------------------------------------------------------------
// Tilt average face match: assertion macros
// Shared helpers for concurrent checks in the core.
// ----------------------------------------------------------------------------
`ifndef TILT_AVERAGE_FACE_MATCH_CORE_DEFINES_SVH
`define TILT_AVERAGE_FACE_MATCH_CORE_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TAFM_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define TAFM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/tafm_pkg.sv =====
// ----------------------------------------------------------------------------
// Tilt average face match: package
// Beat types, register map and fixed field widths.
// ----------------------------------------------------------------------------
package tafm_pkg;

   // fixed field widths
   localparam int AXIS_W     = 16;
   localparam int SLOT_W     = 5;
   localparam int THR_W      = 15;
   localparam int TOL_W      = 16;
   localparam int FIU_W      = 6;
   localparam int SPB_W      = 5;
   localparam int NUM_AXES   = 3;
   localparam int AXIS_IDX_W = 2;
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   // operation codes
   localparam logic OP_LOAD   = 1'b0;
   localparam logic OP_SAMPLE = 1'b1;

   // register indexes (paddr[3:2])
   typedef enum logic [1:0] {
      CSR_ZERO_THRESHOLD    = 2'd0,
      CSR_MATCH_TOLERANCE   = 2'd1,
      CSR_FACES_IN_USE      = 2'd2,
      CSR_SAMPLES_PER_BATCH = 2'd3
   } csr_index_type;

   // register reset values
   localparam logic [THR_W-1:0] RST_ZERO_THRESHOLD    = 15'd81;
   localparam logic [TOL_W-1:0] RST_MATCH_TOLERANCE   = 16'd1639;
   localparam logic [FIU_W-1:0] RST_FACES_IN_USE      = 6'd20;
   localparam logic [SPB_W-1:0] RST_SAMPLES_PER_BATCH = 5'd10;

   // axis indexes
   localparam logic [AXIS_IDX_W-1:0] AXIS_X = 2'd0;
   localparam logic [AXIS_IDX_W-1:0] AXIS_Y = 2'd1;
   localparam logic [AXIS_IDX_W-1:0] AXIS_Z = 2'd2;

   typedef struct packed {
      logic                     operation;
      logic [SLOT_W-1:0]        face_slot;
      logic signed [AXIS_W-1:0] ref_x;
      logic signed [AXIS_W-1:0] ref_y;
      logic signed [AXIS_W-1:0] ref_z;
      logic signed [AXIS_W-1:0] sample_x;
      logic signed [AXIS_W-1:0] sample_y;
      logic signed [AXIS_W-1:0] sample_z;
   } req_beat_type;

   typedef struct packed {
      logic                     face_found;
      logic [SLOT_W-1:0]        face_number;
      logic signed [AXIS_W-1:0] mean_x;
      logic signed [AXIS_W-1:0] mean_y;
      logic signed [AXIS_W-1:0] mean_z;
   } rsp_beat_type;

   // one three-axis vector (face entry or batch means)
   typedef struct packed {
      logic signed [AXIS_W-1:0] x;
      logic signed [AXIS_W-1:0] y;
      logic signed [AXIS_W-1:0] z;
   } vec3_type;

   // face search outcome
   typedef struct packed {
      logic              found;
      logic [SLOT_W-1:0] number;
   } search_result_type;

endpackage

// ===== src/tilt_average_face_match_core.sv =====
// ----------------------------------------------------------------------------
// Tilt average face match core
// Averages batches of accelerometer samples and finds the matching face.
// ----------------------------------------------------------------------------
// Usage:
//   Input beats are taken when start is high and busy is low. A load beat
//   (operation 0) writes one face table entry in that cycle and leaves busy
//   low. A sample beat raises busy while it is folded into the per-axis
//   accumulators, one read and one write-back of the accumulator memory per
//   axis, and no new sample is taken until it has been folded in.
//   The sample that closes a batch also runs the average and the search:
//   the shared serial divider divides the three axis sums in turn (the sum
//   width SUM_W is 17 + log2(MAX_BATCH), 21 by default; an axis with no
//   qualifying reading ends early), then the search walks the face memory's
//   single read port, and the result beat follows.
//   The result beat sits on rsp_data for one cycle with rsp_strobe high and
//   busy drops in that same cycle; the receiver cannot stall it.
//   Reset clears the accumulators (valid bits), the batch count and the
//   registers to their defaults; the face table is undefined until loaded.
//   The user must write registers over the APB port only while busy is low; the block does not enforce it.
// ----------------------------------------------------------------------------
`include "tilt_average_face_match_core_defines.svh"

module tilt_average_face_match_core
   import tafm_pkg::*;
#(
   parameter int FACE_SLOTS = 32,
   parameter int MAX_BATCH  = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   // input channel
   input  logic                  start,
   output logic                  busy,
   input  req_beat_type          req_data,
   // result channel
   output logic                  rsp_strobe,
   output rsp_beat_type          rsp_data,
   // register port
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   localparam int SUM_W = 17 + $clog2(MAX_BATCH);
   localparam int CNT_W = $clog2(MAX_BATCH + 1);
   localparam int BAT_W = (CNT_W > SPB_W) ? CNT_W : SPB_W;

   typedef enum logic [6:0] {
      ST_IDLE     = 7'b0000001,
      ST_ACC_RD   = 7'b0000010,
      ST_ACC_WR   = 7'b0000100,
      ST_DIV_RD   = 7'b0001000,
      ST_DIV_GO   = 7'b0010000,
      ST_DIV_WAIT = 7'b0100000,
      ST_SEARCH   = 7'b1000000
   } state_type;

   typedef struct packed {
      logic signed [SUM_W-1:0] sum;
      logic [CNT_W-1:0]        cnt;
   } acc_entry_type;

   // registers
   logic [THR_W-1:0] thr_ff, thr_in;
   logic [TOL_W-1:0] tol_ff, tol_in;
   logic [FIU_W-1:0] fiu_ff, fiu_in;
   logic [SPB_W-1:0] spb_ff, spb_in;
   logic             csr_we;
   csr_index_type    csr_idx;

   // control
   state_type                state_ff, state_in;
   logic [AXIS_IDX_W-1:0]    axis_ff, axis_in;
   logic [CNT_W-1:0]         scount_ff, scount_in;
   vec3_type                 sample_ff, sample_in;
   vec3_type                 mean_ff, mean_in;
   logic                     rsp_strobe_ff, rsp_strobe_in;
   rsp_beat_type             rsp_data_ff, rsp_data_in;

   // accumulator memory
   acc_entry_type            acc_mem [NUM_AXES];
   logic [NUM_AXES-1:0]      acc_vld_ff, acc_vld_in;
   acc_entry_type            acc_rd_ff;
   logic                     acc_rd_vld_ff;
   logic                     acc_re;
   logic                     acc_we;
   acc_entry_type            acc_wdata;
   acc_entry_type            acc_cur;

   // datapath
   logic                     accept;
   logic signed [AXIS_W-1:0] reading;
   logic [AXIS_W:0]          reading_ext;
   logic [AXIS_W:0]          reading_mag;
   logic                     qualify;
   logic [CNT_W-1:0]         scount_next;
   logic [BAT_W-1:0]         spb_ext;
   logic [BAT_W-1:0]         batch;
   logic                     batch_end;

   // divider and search links
   logic                     div_start;
   logic                     div_done;
   logic signed [AXIS_W-1:0] div_quo;
   logic                     srch_start;
   logic                     srch_done;
   search_result_type        srch_result;
   vec3_type                 load_entry;

   // ---------------- register port ----------------
   assign csr_we  = psel && penable && pwrite;
   assign csr_idx = csr_index_type'(paddr[3:2]);
   assign pready  = 1'b1;

   always_comb begin
      thr_in = thr_ff;
      tol_in = tol_ff;
      fiu_in = fiu_ff;
      spb_in = spb_ff;
      if (csr_we) begin
         case (csr_idx)
            CSR_ZERO_THRESHOLD: begin
               thr_in = pwdata[THR_W-1:0];
            end
            CSR_MATCH_TOLERANCE: begin
               tol_in = pwdata[TOL_W-1:0];
            end
            CSR_FACES_IN_USE: begin
               fiu_in = pwdata[FIU_W-1:0];
            end
            CSR_SAMPLES_PER_BATCH: begin
               spb_in = pwdata[SPB_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         CSR_ZERO_THRESHOLD:    prdata = CSR_DATA_W'(thr_ff);
         CSR_MATCH_TOLERANCE:   prdata = CSR_DATA_W'(tol_ff);
         CSR_FACES_IN_USE:      prdata = CSR_DATA_W'(fiu_ff);
         CSR_SAMPLES_PER_BATCH: prdata = CSR_DATA_W'(spb_ff);
         default:               prdata = '0;
      endcase
   end

   // ---------------- sample datapath ----------------
   assign accept = start && (state_ff == ST_IDLE);

   // axis reading picked by the sequencer
   always_comb begin
      case (axis_ff)
         AXIS_X:  reading = sample_ff.x;
         AXIS_Y:  reading = sample_ff.y;
         AXIS_Z:  reading = sample_ff.z;
         default: reading = '0;
      endcase
      reading_ext = {reading[AXIS_W-1], reading};
      reading_mag = reading[AXIS_W-1] ? ((AXIS_W + 1)'(0) - reading_ext) : reading_ext;
      qualify     = reading_mag > {2'b00, thr_ff};
   end

   // read-modify-write value; invalid entries read as zero
   always_comb begin
      acc_cur   = acc_rd_vld_ff ? acc_rd_ff : '0;
      acc_wdata = acc_cur;
      if (qualify) begin
         acc_wdata.sum = acc_cur.sum + {{(SUM_W - AXIS_W){reading[AXIS_W-1]}}, reading};
         acc_wdata.cnt = acc_cur.cnt + 1'b1;
      end
   end

   // effective batch size: zero acts as one, capped at MAX_BATCH
   always_comb begin
      spb_ext = BAT_W'(spb_ff);
      if (spb_ff == '0) begin
         batch = BAT_W'(1);
      end else if (spb_ext > BAT_W'(MAX_BATCH)) begin
         batch = BAT_W'(MAX_BATCH);
      end else begin
         batch = spb_ext;
      end
      scount_next = scount_ff + 1'b1;
      batch_end   = BAT_W'(scount_next) >= batch;
   end

   // ---------------- sequencer ----------------
   always_comb begin
      state_in      = state_ff;
      axis_in       = axis_ff;
      scount_in     = scount_ff;
      sample_in     = sample_ff;
      mean_in       = mean_ff;
      acc_vld_in    = acc_vld_ff;
      acc_re        = 1'b0;
      acc_we        = 1'b0;
      div_start     = 1'b0;
      srch_start    = 1'b0;
      rsp_strobe_in = 1'b0;
      rsp_data_in   = rsp_data_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && (req_data.operation == OP_SAMPLE)) begin
               sample_in.x = req_data.sample_x;
               sample_in.y = req_data.sample_y;
               sample_in.z = req_data.sample_z;
               axis_in     = AXIS_X;
               state_in    = ST_ACC_RD;
            end
         end
         ST_ACC_RD: begin
            acc_re   = 1'b1;
            state_in = ST_ACC_WR;
         end
         ST_ACC_WR: begin
            acc_we              = 1'b1;
            acc_vld_in[axis_ff] = 1'b1;
            if (axis_ff == AXIS_Z) begin
               axis_in = AXIS_X;
               if (batch_end) begin
                  scount_in = '0;
                  state_in  = ST_DIV_RD;
               end else begin
                  scount_in = scount_next;
                  state_in  = ST_IDLE;
               end
            end else begin
               axis_in  = axis_ff + 1'b1;
               state_in = ST_ACC_RD;
            end
         end
         ST_DIV_RD: begin
            acc_re   = 1'b1;
            state_in = ST_DIV_GO;
         end
         ST_DIV_GO: begin
            // hand the totals to the divider and clear the entry
            div_start           = 1'b1;
            acc_vld_in[axis_ff] = 1'b0;
            state_in            = ST_DIV_WAIT;
         end
         ST_DIV_WAIT: begin
            if (div_done) begin
               case (axis_ff)
                  AXIS_X:  mean_in.x = div_quo;
                  AXIS_Y:  mean_in.y = div_quo;
                  default: mean_in.z = div_quo;
               endcase
               if (axis_ff == AXIS_Z) begin
                  srch_start = 1'b1;
                  state_in   = ST_SEARCH;
               end else begin
                  axis_in  = axis_ff + 1'b1;
                  state_in = ST_DIV_RD;
               end
            end
         end
         ST_SEARCH: begin
            if (srch_done) begin
               rsp_strobe_in           = 1'b1;
               rsp_data_in.face_found  = srch_result.found;
               rsp_data_in.face_number = srch_result.number;
               rsp_data_in.mean_x      = mean_ff.x;
               rsp_data_in.mean_y      = mean_ff.y;
               rsp_data_in.mean_z      = mean_ff.z;
               state_in                = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff        <= RST_ZERO_THRESHOLD;
         tol_ff        <= RST_MATCH_TOLERANCE;
         fiu_ff        <= RST_FACES_IN_USE;
         spb_ff        <= RST_SAMPLES_PER_BATCH;
         state_ff      <= ST_IDLE;
         axis_ff       <= AXIS_X;
         scount_ff     <= '0;
         acc_vld_ff    <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         thr_ff        <= thr_in;
         tol_ff        <= tol_in;
         fiu_ff        <= fiu_in;
         spb_ff        <= spb_in;
         state_ff      <= state_in;
         axis_ff       <= axis_in;
         scount_ff     <= scount_in;
         acc_vld_ff    <= acc_vld_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
      sample_ff   <= sample_in;
      mean_ff     <= mean_in;
      rsp_data_ff <= rsp_data_in;
   end

   // accumulator memory, registered read
   always_ff @(posedge clock) begin
      if (acc_we) begin
         acc_mem[axis_ff] <= acc_wdata;
      end
      if (acc_re) begin
         acc_rd_ff     <= acc_mem[axis_ff];
         acc_rd_vld_ff <= acc_vld_ff[axis_ff];
      end
   end

   // ---------------- units ----------------
   tafm_divider #(
      .SUM_W (SUM_W),
      .CNT_W (CNT_W)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (acc_cur.sum),
      .divisor  (acc_cur.cnt),
      .done     (div_done),
      .quotient (div_quo)
   );

   assign load_entry.x = req_data.ref_x;
   assign load_entry.y = req_data.ref_y;
   assign load_entry.z = req_data.ref_z;

   tafm_face_search #(
      .FACE_SLOTS (FACE_SLOTS)
   ) u_face_search (
      .clock        (clock),
      .reset        (reset),
      .load_we      (accept && (req_data.operation == OP_LOAD)),
      .load_slot    (req_data.face_slot),
      .load_entry   (load_entry),
      .start        (srch_start),
      .means        (mean_ff),
      .faces_in_use (fiu_ff),
      .tolerance    (tol_ff),
      .done         (srch_done),
      .result       (srch_result)
   );

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

   // ---------------- checks ----------------
   `TAFM_ASSERT_NEXT(a_strobe_single, clock, reset, rsp_strobe, !rsp_strobe, "result strobe longer than one cycle")
   `TAFM_ASSERT_NEXT(a_sample_busy, clock, reset, start && !busy && (req_data.operation == OP_SAMPLE), busy, "sample beat did not raise busy")
   `TAFM_ASSERT_NOW(a_miss_number, clock, reset, rsp_strobe && !rsp_data.face_found, rsp_data.face_number == '0, "face number nonzero on a miss")
   `TAFM_ASSERT_NOW(a_div_state, clock, reset, div_done, state_ff == ST_DIV_WAIT, "divider finished outside its wait state")

endmodule

// ===== src/tafm_divider.sv =====
// ----------------------------------------------------------------------------
// Tilt average face match: serial divider
// Signed sum over unsigned count, truncated toward zero, one bit per cycle.
// A zero count gives a zero quotient.
// ----------------------------------------------------------------------------
module tafm_divider
   import tafm_pkg::*;
#(
   parameter int SUM_W = 21,
   parameter int CNT_W = 5
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic signed [SUM_W-1:0]  dividend,
   input  logic [CNT_W-1:0]         divisor,
   output logic                     done,
   output logic signed [AXIS_W-1:0] quotient
);

   localparam int STEP_W = $clog2(SUM_W + 1);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [SUM_W-1:0]  quo_ff, quo_in;
   logic [CNT_W-1:0]  rem_ff, rem_in;
   logic [CNT_W-1:0]  dsr_ff, dsr_in;
   logic              neg_ff, neg_in;
   logic              zero_ff, zero_in;

   logic [CNT_W:0]    rem_shift;
   logic [CNT_W+1:0]  diff;
   logic              ge;
   logic [SUM_W-1:0]  mag;
   logic [SUM_W-1:0]  signed_quo;

   // trial subtract of one quotient bit
   always_comb begin
      rem_shift = {rem_ff, quo_ff[SUM_W-1]};
      diff      = {1'b0, rem_shift} - {2'b00, dsr_ff};
      ge        = ~diff[CNT_W+1];
      mag       = dividend[SUM_W-1] ? (SUM_W'(0) - dividend) : dividend;
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      neg_in  = neg_ff;
      zero_in = zero_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = STEP_W'(SUM_W);
         quo_in  = mag;
         rem_in  = '0;
         dsr_in  = divisor;
         neg_in  = dividend[SUM_W-1];
         zero_in = (divisor == '0);
      end else if (busy_ff) begin
         if ((step_ff == '0) || zero_ff) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            step_in = step_ff - 1'b1;
            quo_in  = {quo_ff[SUM_W-2:0], ge};
            rem_in  = ge ? diff[CNT_W-1:0] : rem_shift[CNT_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      step_ff <= step_in;
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
      dsr_ff  <= dsr_in;
      neg_ff  <= neg_in;
      zero_ff <= zero_in;
   end

   // apply sign; quotient magnitude always fits the axis width
   assign signed_quo = neg_ff ? (SUM_W'(0) - quo_ff) : quo_ff;
   assign quotient   = zero_ff ? '0 : signed_quo[AXIS_W-1:0];
   assign done       = done_ff;

endmodule

// ===== src/tafm_face_search.sv =====
// ----------------------------------------------------------------------------
// Tilt average face match: face table and search
// Face reference memory with one write port for loads and a registered read
// port that the search walks one entry per cycle, stopping at the first hit.
// ----------------------------------------------------------------------------
module tafm_face_search
   import tafm_pkg::*;
#(
   parameter int FACE_SLOTS = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              load_we,
   input  logic [SLOT_W-1:0] load_slot,
   input  vec3_type          load_entry,
   input  logic              start,
   input  vec3_type          means,
   input  logic [FIU_W-1:0]  faces_in_use,
   input  logic [TOL_W-1:0]  tolerance,
   output logic              done,
   output search_result_type result
);

   localparam int ADDR_W = (FACE_SLOTS > 1) ? $clog2(FACE_SLOTS) : 1;
   localparam int LIM_RAW = $clog2(FACE_SLOTS + 1);
   localparam int LIM_W = (LIM_RAW > FIU_W) ? LIM_RAW : FIU_W;

   vec3_type face_mem [FACE_SLOTS];

   logic              active_ff, active_in;
   logic [LIM_W-1:0]  next_ff, next_in;
   logic              rd_vld_ff;
   logic [LIM_W-1:0]  rd_idx_ff;
   vec3_type          rd_data_ff;
   logic              done_ff;
   search_result_type result_ff, result_in;

   logic [LIM_W-1:0]  fiu_ext;
   logic [LIM_W-1:0]  lim;
   logic [LIM_W-1:0]  slot_ext;
   logic              slot_ok;
   logic              hit;
   logic              finish;
   logic              issue;

   // per-axis distance check against tolerance
   function automatic logic axis_ok(input logic signed [AXIS_W-1:0] a,
                                    input logic signed [AXIS_W-1:0] b,
                                    input logic [TOL_W-1:0] tol);
      logic [AXIS_W:0] d;
      logic [AXIS_W:0] m;
      d = {a[AXIS_W-1], a} - {b[AXIS_W-1], b};
      m = d[AXIS_W] ? ((AXIS_W + 1)'(0) - d) : d;
      return m <= {1'b0, tol};
   endfunction

   // search limit, capped at table depth
   always_comb begin
      fiu_ext  = LIM_W'(faces_in_use);
      lim      = (fiu_ext > LIM_W'(FACE_SLOTS)) ? LIM_W'(FACE_SLOTS) : fiu_ext;
      slot_ext = LIM_W'(load_slot);
      slot_ok  = slot_ext < LIM_W'(FACE_SLOTS);
   end

   // compare the entry read last cycle, decide whether to go on
   always_comb begin
      hit = axis_ok(means.x, rd_data_ff.x, tolerance) &&
            axis_ok(means.y, rd_data_ff.y, tolerance) &&
            axis_ok(means.z, rd_data_ff.z, tolerance);
      finish = active_ff &&
               ((rd_vld_ff && (hit || (rd_idx_ff == (lim - 1'b1)))) ||
                (!rd_vld_ff && (next_ff >= lim)));
      issue  = active_ff && !finish && (next_ff < lim);
   end

   always_comb begin
      active_in = active_ff;
      next_in   = next_ff;
      result_in = result_ff;
      if (start) begin
         active_in = 1'b1;
         next_in   = '0;
      end else begin
         if (issue) begin
            next_in = next_ff + 1'b1;
         end
         if (finish) begin
            active_in        = 1'b0;
            result_in.found  = rd_vld_ff && hit;
            result_in.number = (rd_vld_ff && hit) ? rd_idx_ff[SLOT_W-1:0] : '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         rd_vld_ff <= 1'b0;
         done_ff   <= 1'b0;
      end else begin
         active_ff <= active_in;
         rd_vld_ff <= issue && !start;
         done_ff   <= finish && !start;
      end
      next_ff   <= next_in;
      rd_idx_ff <= next_ff;
      result_ff <= result_in;
   end

   // face memory: load writes, search reads through a register
   always_ff @(posedge clock) begin
      if (load_we && slot_ok) begin
         face_mem[slot_ext[ADDR_W-1:0]] <= load_entry;
      end
      if (issue) begin
         rd_data_ff <= face_mem[next_ff[ADDR_W-1:0]];
      end
   end

   assign done   = done_ff;
   assign result = result_ff;

endmodule
